>>> rtl/hpcs_pkg.sv
// Shared types, widths and constants of the heater PI controller.
package hpcs_pkg;

  // Field widths
  localparam int TEMP_W     = 19;
  localparam int ERR_W      = 20;
  localparam int DUTY_W     = 10;
  localparam int INTEG_W    = 21;
  localparam int TARGET_W   = 18;
  localparam int GAIN_W     = 10;
  localparam int LIMIT_W    = 20;
  localparam int SHIFT_W    = 4;
  localparam int INTERVAL_W = 13;

  // Stream packing
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_USED_W  = DUTY_W + TEMP_W + ERR_W;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // Config port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KP       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KI       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DUTY_MAX = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL = 3'd7;

  // Multiply / divide-by-1000 unit
  localparam int MUL_A_W        = INTEG_W;
  localparam int MUL_B_W        = INTERVAL_W;
  localparam int PROD_W         = MUL_A_W + MUL_B_W + 1;
  localparam int QUOT_W         = 25;
  // every product magnitude stays below 2^32
  localparam int MAG_W          = 32;
  // floor(x * RECIP_1000 / 2^38) equals floor(x / 1000) for every x below 2^32
  localparam int RECIP_W        = 29;
  localparam int RPROD_W        = MAG_W + RECIP_W;
  localparam int RECIP_SHIFT    = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

  // Wide accumulation of two quotients or integral plus quotient
  localparam int ACC_W = 26;

  typedef struct packed {
    logic [TARGET_W-1:0]   target_temp_mc;
    logic [GAIN_W-1:0]     kp_gain;
    logic [GAIN_W-1:0]     ki_gain;
    logic [LIMIT_W-1:0]    integral_limit;
    logic [DUTY_W-1:0]     duty_max;
    logic [DUTY_W-1:0]     duty_step;
    logic [SHIFT_W-1:0]    smooth_shift;
    logic [INTERVAL_W-1:0] interval_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    target_temp_mc: 18'd40000,
    kp_gain:        10'd25,
    ki_gain:        10'd2,
    integral_limit: 20'd180000,
    duty_max:       10'd600,
    duty_step:      10'd50,
    smooth_shift:   4'd2,
    interval_ms:    13'd500
  };

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } muldiv_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUOT_W-1:0] quot;
  } muldiv_rsp_t;

endpackage

>>> rtl/heater_pi_controller_slew.sv
// Heater PI controller: input filter, clamped integral, duty clamp and slew limit.
//
// Use:
//   s_axis: one beat per control tick. tdata[18:0] is the temperature sample
//   in millidegrees (signed), tuser[0] says the read succeeded.
//   m_axis: one beat per tick. tdata holds heater_duty, filtered_temp_mc and
//   temp_error_mc; tuser[0] flags a tick forced off by a failed read.
//   cfg: single-cycle register writes (index 0..7); the user must write only while idle, the block does not enforce it.
// Sequence:
//   A good sample passes filter and error, then the shared multiply /
//   divide-by-1000 unit three times (multiply, magnitude, reciprocal
//   multiply, handoff), then clamp, slew and output load; a failed read
//   goes straight to output load. The next input beat is taken in the cycle
//   after the result is loaded, so only one sample is in the block at a time.
// Reset clears filter, integral and last duty, marks the filter unseeded and
// loads the default registers. A stalled receiver holds the result in the
// output register; one more input beat is taken and then held until it drains.
module heater_pi_controller_slew (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // cfg write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hpcs_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [hpcs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [hpcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // [18:0] temp_sample_mc
  input  logic [0:0]                       s_axis_tuser_i,   // [0] sample_valid
  // output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [hpcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,   // [9:0] heater_duty,
                                                             // [28:10] filtered_temp_mc,
                                                             // [48:29] temp_error_mc
  output logic [0:0]                       m_axis_tuser_o    // [0] forced_off
);
  import hpcs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FILT  = 8'b0000_0010,
    S_ERR   = 8'b0000_0100,
    S_ISSUE = 8'b0000_1000,
    S_WAIT  = 8'b0001_0000,
    S_CLAMP = 8'b0010_0000,
    S_SLEW  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    OP_INTEG,
    OP_PROP,
    OP_ITERM
  } op_e;

  cfg_t        cfg;
  muldiv_req_t md_req;
  muldiv_rsp_t md_rsp;

  state_e                   state_q, state_d;
  op_e                      op_q, op_d;
  logic                     seeded_q, seeded_d;
  logic signed [TEMP_W-1:0] filt_q, filt_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic [DUTY_W-1:0]        last_duty_q, last_duty_d;
  logic signed [TEMP_W-1:0] sample_q, sample_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [QUOT_W-1:0] pterm_q, pterm_d;
  logic signed [ACC_W-1:0]  sum_q, sum_d;
  logic [DUTY_W-1:0]        duty_c_q, duty_c_d;
  logic [DUTY_W-1:0]        res_duty_q, res_duty_d;
  logic signed [ERR_W-1:0]  res_err_q, res_err_d;
  logic                     res_forced_q, res_forced_d;
  logic                     m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0]   m_data_q, m_data_d;
  logic                     m_user_q, m_user_d;

  logic                     in_beat;
  logic signed [ERR_W-1:0]  diff, fstep, fsum;
  logic signed [ACC_W-1:0]  isum, lim_pos, lim_neg, dmax_ext;
  logic [DUTY_W:0]          slew_hi, slew_lo_chk;
  logic [DUTY_W-1:0]        duty_fin;

  hpcs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hpcs_muldiv u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (md_req),
    .rsp_o (md_rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // filter update terms
  assign diff  = ERR_W'(sample_q) - ERR_W'(filt_q);
  assign fstep = diff >>> cfg.smooth_shift;
  assign fsum  = ERR_W'(filt_q) + fstep;

  // integral clamp terms
  assign isum     = ACC_W'(integ_q) + ACC_W'(md_rsp.quot);
  assign lim_pos  = ACC_W'($signed({1'b0, cfg.integral_limit}));
  assign lim_neg  = -lim_pos;
  assign dmax_ext = ACC_W'($signed({1'b0, cfg.duty_max}));

  // slew limit against the previous duty
  assign slew_hi     = {1'b0, last_duty_q} + {1'b0, cfg.duty_step};
  assign slew_lo_chk = {1'b0, duty_c_q} + {1'b0, cfg.duty_step};

  always_comb begin
    if ({1'b0, duty_c_q} > slew_hi) begin
      duty_fin = slew_hi[DUTY_W-1:0];
    end else if ({1'b0, last_duty_q} > slew_lo_chk) begin
      duty_fin = last_duty_q - cfg.duty_step;
    end else begin
      duty_fin = duty_c_q;
    end
  end

  // operand select for the shared unit
  always_comb begin
    md_req.start = (state_q == S_ISSUE);
    unique case (op_q)
      OP_INTEG: begin
        md_req.a = MUL_A_W'(err_q);
        md_req.b = cfg.interval_ms;
      end
      OP_PROP: begin
        md_req.a = MUL_A_W'(err_q);
        md_req.b = MUL_B_W'(cfg.kp_gain);
      end
      OP_ITERM: begin
        md_req.a = integ_q;
        md_req.b = MUL_B_W'(cfg.ki_gain);
      end
      default: begin
        md_req.a = '0;
        md_req.b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    seeded_d     = seeded_q;
    filt_d       = filt_q;
    integ_d      = integ_q;
    last_duty_d  = last_duty_q;
    sample_d     = sample_q;
    err_d        = err_q;
    pterm_d      = pterm_q;
    sum_d        = sum_q;
    duty_c_d     = duty_c_q;
    res_duty_d   = res_duty_q;
    res_err_d    = res_err_q;
    res_forced_d = res_forced_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;

    // output beat taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          sample_d = $signed(s_axis_tdata_i[TEMP_W-1:0]);
          if (s_axis_tuser_i[0]) begin
            res_forced_d = 1'b0;
            state_d      = S_FILT;
          end else begin
            // failed read: heater off, state untouched
            res_duty_d   = '0;
            res_err_d    = '0;
            res_forced_d = 1'b1;
            state_d      = S_OUT;
          end
        end
      end
      S_FILT: begin
        if (!seeded_q) begin
          filt_d   = sample_q;
          seeded_d = 1'b1;
        end else begin
          filt_d = fsum[TEMP_W-1:0];
        end
        state_d = S_ERR;
      end
      S_ERR: begin
        err_d   = ERR_W'($signed({1'b0, cfg.target_temp_mc})) - ERR_W'(filt_q);
        op_d    = OP_INTEG;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (md_rsp.done) begin
          unique case (op_q)
            OP_INTEG: begin
              if (isum < lim_neg) begin
                integ_d = lim_neg[INTEG_W-1:0];
              end else if (isum > lim_pos) begin
                integ_d = lim_pos[INTEG_W-1:0];
              end else begin
                integ_d = isum[INTEG_W-1:0];
              end
              op_d    = OP_PROP;
              state_d = S_ISSUE;
            end
            OP_PROP: begin
              pterm_d = md_rsp.quot;
              op_d    = OP_ITERM;
              state_d = S_ISSUE;
            end
            OP_ITERM: begin
              sum_d   = ACC_W'(pterm_q) + ACC_W'(md_rsp.quot);
              state_d = S_CLAMP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLAMP: begin
        if (sum_q < 0) begin
          duty_c_d = '0;
        end else if (sum_q > dmax_ext) begin
          duty_c_d = cfg.duty_max;
        end else begin
          duty_c_d = sum_q[DUTY_W-1:0];
        end
        state_d = S_SLEW;
      end
      S_SLEW: begin
        last_duty_d = duty_fin;
        res_duty_d  = duty_fin;
        res_err_d   = err_q;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {{OUT_PAD_W{1'b0}}, res_err_q, filt_q, res_duty_q};
          m_user_d  = res_forced_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_INTEG;
      seeded_q    <= 1'b0;
      filt_q      <= '0;
      integ_q     <= '0;
      last_duty_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      seeded_q    <= seeded_d;
      filt_q      <= filt_d;
      integ_q     <= integ_d;
      last_duty_q <= last_duty_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q     <= sample_d;
    err_q        <= err_d;
    pterm_q      <= pterm_d;
    sum_q        <= sum_d;
    duty_c_q     <= duty_c_d;
    res_duty_q   <= res_duty_d;
    res_err_q    <= res_err_d;
    res_forced_q <= res_forced_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_user_q;

endmodule

>>> rtl/hpcs_cfg.sv
// Configuration register file of the heater PI controller.
module hpcs_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hpcs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [hpcs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output hpcs_pkg::cfg_t                  cfg_o
);
  import hpcs_pkg::*;

  cfg_t cfg_q;

  // writes are always accepted and land in the register
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_TARGET:   cfg_q.target_temp_mc <= cfg_data_i[TARGET_W-1:0];
        REG_KP:       cfg_q.kp_gain        <= cfg_data_i[GAIN_W-1:0];
        REG_KI:       cfg_q.ki_gain        <= cfg_data_i[GAIN_W-1:0];
        REG_LIMIT:    cfg_q.integral_limit <= cfg_data_i[LIMIT_W-1:0];
        REG_DUTY_MAX: cfg_q.duty_max       <= cfg_data_i[DUTY_W-1:0];
        REG_STEP:     cfg_q.duty_step      <= cfg_data_i[DUTY_W-1:0];
        REG_SHIFT:    cfg_q.smooth_shift   <= cfg_data_i[SHIFT_W-1:0];
        REG_INTERVAL: cfg_q.interval_ms    <= cfg_data_i[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/hpcs_muldiv.sv
// Shared signed multiplier followed by a reciprocal divide by 1000 (truncating toward zero).
module hpcs_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hpcs_pkg::muldiv_req_t req_i,
  output hpcs_pkg::muldiv_rsp_t rsp_o
);
  import hpcs_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE  = 3'b001,
    MD_LOAD  = 3'b010,
    MD_RECIP = 3'b100
  } md_state_e;

  md_state_e                md_q, md_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PROD_W-1:0] a_ext, b_ext;
  logic [PROD_W-1:0]        mag;
  logic                     neg_q, neg_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic [RPROD_W-1:0]       rprod_q, rprod_d;
  logic                     done_q, done_d;
  logic signed [QUOT_W-1:0] qmag;

  assign a_ext = PROD_W'(req_i.a);
  assign b_ext = PROD_W'($signed({1'b0, req_i.b}));
  assign mag   = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);

  // sequencer: product, magnitude, reciprocal multiply
  always_comb begin
    md_d    = md_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    rprod_d = rprod_q;
    done_d  = 1'b0;
    unique case (md_q)
      MD_IDLE: begin
        if (req_i.start) begin
          prod_d = a_ext * b_ext;
          md_d   = MD_LOAD;
        end
      end
      MD_LOAD: begin
        neg_d = prod_q[PROD_W-1];
        mag_d = mag[MAG_W-1:0];
        md_d  = MD_RECIP;
      end
      MD_RECIP: begin
        rprod_d = RPROD_W'(mag_q) * RPROD_W'(RECIP_1000);
        done_d  = 1'b1;
        md_d    = MD_IDLE;
      end
      default: md_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q   <= MD_IDLE;
      done_q <= 1'b0;
    end else begin
      md_q   <= md_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    rprod_q <= rprod_d;
  end

  // restore the sign of the quotient
  assign qmag       = $signed(QUOT_W'(rprod_q[RPROD_W-1:RECIP_SHIFT]));
  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -qmag : qmag;

endmodule

>>> rtl/hpcs_checker.sv
// Port-level checks of the heater PI controller and their bind.
module hpcs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [hpcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]                       m_axis_tuser_o
);
  import hpcs_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

  // one tick at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a tick is in progress");

  // forced-off beat carries zero duty and zero error
  a_forced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      m_axis_tdata_o[DUTY_W-1:0] == '0 &&
      m_axis_tdata_o[OUT_USED_W-1:DUTY_W+TEMP_W] == '0)
    else $error("forced-off beat with nonzero duty or error");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_TDATA_W-1:OUT_USED_W] == '0)
    else $error("output padding not zero");

endmodule

bind heater_pi_controller_slew hpcs_checker u_hpcs_checker (.*);
